/* rtl/crfb_pkg.sv */
// ----------------------------------------------------------------------------
// crfb_pkg
// shared types and constants for the clipped rectangle fill byte stream
// ----------------------------------------------------------------------------
package crfb_pkg;

    localparam int MAX_DIM  = 512;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int SPAN_W   = 18;
    localparam int ADDR_W   = 16;
    localparam int BL_W     = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int PANEL_W  = 10;
    localparam int OFF_W    = 8;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 10'd128;
    localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 10'd160;

    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COL_OFFSET   = 2'd2;
    localparam logic [1:0] REG_ROW_OFFSET   = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PULL  = 1'b1;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    typedef struct packed {
        logic [PANEL_W-1:0] panel_width;
        logic [PANEL_W-1:0] panel_height;
        logic [OFF_W-1:0]   column_offset;
        logic [OFF_W-1:0]   row_base;
    } cfg_t;

    typedef struct packed {
        logic             empty;
        logic [DIM_W-1:0] first;
        logic [DIM_W-1:0] last;
        logic [DIM_W-1:0] count;
    } clip_t;

endpackage

/* rtl/clipped_rect_fill_byte_stream.sv */
// ----------------------------------------------------------------------------
// clipped_rect_fill_byte_stream
// clips a rectangle to the panel and streams window commands and fill bytes
// ----------------------------------------------------------------------------
// a pull word passes the input word register, then the output register, before m_tvalid shows its byte
// throughput: one word per cycle through the combinational clip and sequencer;
// input stalls only while the output register holds an unaccepted word
// a start word is absorbed and yields no output word
// reset: rst_n clears the transfer and both word registers, panel 128x160,
// offsets zero
module clipped_rect_fill_byte_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // left, top, rect_width, rect_height, fill_color
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tuser,   // is_data
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crfb_pkg::cfg_t cfg;

    crfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crfb_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last word flagged as command");

    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == crfb_pkg::CMD_COL_ADDR
                                    || m_tdata == crfb_pkg::CMD_ROW_ADDR
                                    || m_tdata == crfb_pkg::CMD_MEM_WRITE))
        else $error("unknown command byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_word_after_pull: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(s_tready))
        else $error("output word appeared without the sequencer advancing");

endmodule

/* rtl/crfb_cfg.sv */
// ----------------------------------------------------------------------------
// crfb_cfg
// apb register file holding panel size and address offsets
// ----------------------------------------------------------------------------
module crfb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [crfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [crfb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output crfb_pkg::cfg_t                cfg
);

    crfb_pkg::cfg_t cfg_reg;
    crfb_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                crfb_pkg::REG_PANEL_WIDTH:
                    cfg_next.panel_width = pwdata[crfb_pkg::PANEL_W-1:0];
                crfb_pkg::REG_PANEL_HEIGHT:
                    cfg_next.panel_height = pwdata[crfb_pkg::PANEL_W-1:0];
                crfb_pkg::REG_COL_OFFSET:
                    cfg_next.column_offset = pwdata[crfb_pkg::OFF_W-1:0];
                crfb_pkg::REG_ROW_OFFSET:
                    cfg_next.row_base = pwdata[crfb_pkg::OFF_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            crfb_pkg::REG_PANEL_WIDTH:
                prdata = {{(crfb_pkg::PDATA_W-crfb_pkg::PANEL_W){1'b0}}, cfg_reg.panel_width};
            crfb_pkg::REG_PANEL_HEIGHT:
                prdata = {{(crfb_pkg::PDATA_W-crfb_pkg::PANEL_W){1'b0}}, cfg_reg.panel_height};
            crfb_pkg::REG_COL_OFFSET:
                prdata = {{(crfb_pkg::PDATA_W-crfb_pkg::OFF_W){1'b0}}, cfg_reg.column_offset};
            crfb_pkg::REG_ROW_OFFSET:
                prdata = {{(crfb_pkg::PDATA_W-crfb_pkg::OFF_W){1'b0}}, cfg_reg.row_base};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width   <= crfb_pkg::PANEL_WIDTH_RST;
            cfg_reg.panel_height  <= crfb_pkg::PANEL_HEIGHT_RST;
            cfg_reg.column_offset <= '0;
            cfg_reg.row_base      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/crfb_clip.sv */
// ----------------------------------------------------------------------------
// crfb_clip
// clips one signed span against the panel limit
// ----------------------------------------------------------------------------
module crfb_clip (
    input  logic signed [15:0]              start,
    input  logic        [15:0]              len,
    input  logic [crfb_pkg::PANEL_W-1:0]    panel,
    output crfb_pkg::clip_t                 clip
);

    localparam int SW = crfb_pkg::SPAN_W;
    localparam int DW = crfb_pkg::DIM_W;

    logic        [31:0]   panel_ext;
    logic        [31:0]   max_u;
    logic        [31:0]   limit_w;
    logic signed [SW-1:0] start_s;
    logic signed [SW-1:0] lim_s;
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] hi_c;
    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] last_s;

    assign panel_ext = {{(32-crfb_pkg::PANEL_W){1'b0}}, panel};
    assign max_u     = crfb_pkg::MAX_DIM;
    assign limit_w   = (panel_ext > max_u) ? max_u : panel_ext;
    assign lim_s     = {{(SW-DW){1'b0}}, limit_w[DW-1:0]};

    assign start_s = {{(SW-16){start[15]}}, start};
    assign hi      = start_s + {{(SW-16){1'b0}}, len};
    assign lo      = start[15] ? '0 : start_s;
    assign hi_c    = (hi > lim_s) ? lim_s : hi;
    assign diff    = hi_c - lo;
    assign last_s  = hi_c - {{(SW-1){1'b0}}, 1'b1};

    assign clip.empty = (hi_c <= lo);
    assign clip.first = lo[DW-1:0];
    assign clip.last  = last_s[DW-1:0];
    assign clip.count = diff[DW-1:0];

endmodule

/* rtl/crfb_engine.sv */
// ----------------------------------------------------------------------------
// crfb_engine
// input word register, window state and byte sequencer with output register
// ----------------------------------------------------------------------------
module crfb_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  crfb_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [79:0]     s_tdata,
    input  logic            s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    localparam int AW = crfb_pkg::ADDR_W;
    localparam int DW = crfb_pkg::DIM_W;
    localparam int BW = crfb_pkg::BL_W;

    typedef enum logic [3:0] {
        HDR_COL_CMD, HDR_X0_HI, HDR_X0_LO, HDR_X1_HI, HDR_X1_LO,
        HDR_ROW_CMD, HDR_Y0_HI, HDR_Y0_LO, HDR_Y1_HI, HDR_Y1_LO,
        HDR_MEM_CMD, HDR_PIXELS
    } hdr_t;

    logic             in_valid_reg,  in_valid_next;
    logic             in_cmd_reg,    in_cmd_next;
    logic [79:0]      in_data_reg,   in_data_next;
    logic             active_reg,    active_next;
    hdr_t             hdr_reg,       hdr_next;
    logic [AW-1:0]    bounds_reg [4];
    logic [AW-1:0]    bounds_next [4];
    logic [15:0]      color_reg,     color_next;
    logic [BW-1:0]    left_reg,      left_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             out_data_reg,  out_data_next;
    logic             out_last_reg,  out_last_next;

    logic             advance;
    crfb_pkg::clip_t  clip_x;
    crfb_pkg::clip_t  clip_y;
    logic [2*DW-1:0]  area;
    logic [2*DW:0]    area2;
    logic [BW-1:0]    left_dec;
    logic [7:0]       hdr_byte;
    logic             hdr_is_data;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

    crfb_clip u_clip_x (
        .start (in_data_reg[15:0]),
        .len   (in_data_reg[47:32]),
        .panel (cfg.panel_width),
        .clip  (clip_x)
    );

    crfb_clip u_clip_y (
        .start (in_data_reg[31:16]),
        .len   (in_data_reg[63:48]),
        .panel (cfg.panel_height),
        .clip  (clip_y)
    );

    assign area     = clip_x.count * clip_y.count;
    assign area2    = {area, 1'b0};
    assign left_dec = left_reg - {{(BW-1){1'b0}}, 1'b1};

    always_comb
    begin
        hdr_is_data = 1'b1;
        unique case (hdr_reg)
            HDR_COL_CMD:
            begin
                hdr_byte    = crfb_pkg::CMD_COL_ADDR;
                hdr_is_data = 1'b0;
            end
            HDR_X0_HI:   hdr_byte = bounds_reg[0][15:8];
            HDR_X0_LO:   hdr_byte = bounds_reg[0][7:0];
            HDR_X1_HI:   hdr_byte = bounds_reg[1][15:8];
            HDR_X1_LO:   hdr_byte = bounds_reg[1][7:0];
            HDR_ROW_CMD:
            begin
                hdr_byte    = crfb_pkg::CMD_ROW_ADDR;
                hdr_is_data = 1'b0;
            end
            HDR_Y0_HI:   hdr_byte = bounds_reg[2][15:8];
            HDR_Y0_LO:   hdr_byte = bounds_reg[2][7:0];
            HDR_Y1_HI:   hdr_byte = bounds_reg[3][15:8];
            HDR_Y1_LO:   hdr_byte = bounds_reg[3][7:0];
            HDR_MEM_CMD:
            begin
                hdr_byte    = crfb_pkg::CMD_MEM_WRITE;
                hdr_is_data = 1'b0;
            end
            default:     hdr_byte = left_reg[0] ? color_reg[7:0] : color_reg[15:8];
        endcase
    end

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_cmd_next    = in_cmd_reg;
        in_data_next   = in_data_reg;
        active_next    = active_reg;
        hdr_next       = hdr_reg;
        bounds_next    = bounds_reg;
        color_next     = color_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_byte_next  = out_byte_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            if (s_tvalid)
            begin
                in_cmd_next  = s_tuser;
                in_data_next = s_tdata;
            end
        end

        if (advance)
        begin
            if (in_cmd_reg == crfb_pkg::CMD_START)
            begin
                active_next = 1'b0;
                hdr_next    = HDR_COL_CMD;
                left_next   = '0;
                if (!clip_x.empty && !clip_y.empty)
                begin
                    bounds_next[0] = {{(AW-DW){1'b0}}, clip_x.first}
                                   + {{(AW-crfb_pkg::OFF_W){1'b0}}, cfg.column_offset};
                    bounds_next[1] = {{(AW-DW){1'b0}}, clip_x.last}
                                   + {{(AW-crfb_pkg::OFF_W){1'b0}}, cfg.column_offset};
                    bounds_next[2] = {{(AW-DW){1'b0}}, clip_y.first}
                                   + {{(AW-crfb_pkg::OFF_W){1'b0}}, cfg.row_base};
                    bounds_next[3] = {{(AW-DW){1'b0}}, clip_y.last}
                                   + {{(AW-crfb_pkg::OFF_W){1'b0}}, cfg.row_base};
                    color_next     = in_data_reg[79:64];
                    left_next      = area2[BW-1:0];
                    active_next    = 1'b1;
                end
            end
            else if (active_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = hdr_byte;
                out_data_next  = hdr_is_data;
                out_last_next  = 1'b0;
                if (hdr_reg != HDR_PIXELS)
                begin
                    hdr_next = hdr_t'(hdr_reg + 4'd1);
                end
                else
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        out_last_next = 1'b1;
                        active_next   = 1'b0;
                        hdr_next      = HDR_COL_CMD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_cmd_reg    <= crfb_pkg::CMD_START;
            in_data_reg   <= '0;
            active_reg    <= 1'b0;
            hdr_reg       <= HDR_COL_CMD;
            bounds_reg    <= '{default: '0};
            color_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_data_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            in_cmd_reg    <= in_cmd_next;
            in_data_reg   <= in_data_next;
            active_reg    <= active_next;
            hdr_reg       <= hdr_next;
            bounds_reg    <= bounds_next;
            color_reg     <= color_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the clipped rectangle fill byte stream against an in-bench predictor
// of the window header and fill bytes; directed shapes and register extremes
// come first, then a receiver stall, then random rectangles under three
// idling mixes
// ----------------------------------------------------------------------------
module testbench;

    import crfb_pkg::*;

    localparam int HDR_ROW_CMD = 5;
    localparam int HDR_MEM_CMD = 10;
    localparam int HDR_LEN     = 11;

    typedef struct packed {
        logic [7:0] data;
        logic       is_data;
        logic       last;
    } panel_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // left, top, rect_width, rect_height, fill_color
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_byte
    logic        m_tuser;        // is_data
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    panel_word_t pending_bytes[$];
    int          mismatch_count = 0;
    int          src_idle_pct = 25;
    int          snk_idle_pct = 71;
    logic        sink_hold = 1'b0;

    // predictor state
    logic [PANEL_W-1:0] cfg_width = PANEL_WIDTH_RST;
    logic [PANEL_W-1:0] cfg_height = PANEL_HEIGHT_RST;
    logic [OFF_W-1:0]   cfg_col_off = '0;
    logic [OFF_W-1:0]   cfg_row_off = '0;
    logic               xfer_active = 1'b0;
    int                 hdr_pos = 0;
    logic [15:0]        win_bounds [4] = '{default: '0};
    logic [15:0]        color_hold = '0;
    int unsigned        pix_left = 0;

    clipped_rect_fill_byte_stream i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : check_words
        panel_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: byte %h is_data %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (want.data !== m_tdata || want.is_data !== m_tuser ||
                    want.last !== m_tlast)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.data, want.is_data, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // span length after clipping to the panel, zero when empty
    function automatic int clip_extent(input logic signed [15:0] origin,
                                       input logic [15:0] len,
                                       input logic [PANEL_W-1:0] panel,
                                       output int first);
        int lo;
        int hi;
        int lim;
        lo = origin;
        hi = lo + int'(len);
        lim = (panel > MAX_DIM) ? MAX_DIM : int'(panel);
        if (lo < 0)
            lo = 0;
        if (hi > lim)
            hi = lim;
        first = lo;
        return (hi <= lo) ? 0 : hi - lo;
    endfunction

    function automatic void fill_model_step(input logic cmd, input logic [79:0] data);
        int          cx;
        int          cy;
        int          w;
        int          h;
        int          k;
        logic [15:0] v;
        panel_word_t word;
        if (cmd == CMD_START)
        begin
            xfer_active = 1'b0;
            hdr_pos = 0;
            pix_left = 0;
            w = clip_extent(data[15:0], data[47:32], cfg_width, cx);
            h = clip_extent(data[31:16], data[63:48], cfg_height, cy);
            if (w == 0 || h == 0)
                return;
            win_bounds[0] = 16'(cx + cfg_col_off);
            win_bounds[1] = 16'(cx + cfg_col_off + w - 1);
            win_bounds[2] = 16'(cy + cfg_row_off);
            win_bounds[3] = 16'(cy + cfg_row_off + h - 1);
            color_hold = data[79:64];
            pix_left = 2 * w * h;
            xfer_active = 1'b1;
            return;
        end
        if (!xfer_active)
            return;
        word.last = 1'b0;
        if (hdr_pos < HDR_LEN)
        begin
            if (hdr_pos == 0)
            begin
                word.data = CMD_COL_ADDR;
                word.is_data = 1'b0;
            end
            else if (hdr_pos == HDR_ROW_CMD)
            begin
                word.data = CMD_ROW_ADDR;
                word.is_data = 1'b0;
            end
            else if (hdr_pos == HDR_MEM_CMD)
            begin
                word.data = CMD_MEM_WRITE;
                word.is_data = 1'b0;
            end
            else
            begin
                k = (hdr_pos < HDR_ROW_CMD) ? hdr_pos - 1 : hdr_pos - HDR_ROW_CMD - 1;
                v = win_bounds[((hdr_pos < HDR_ROW_CMD) ? 0 : 2) + k / 2];
                word.data = k[0] ? v[7:0] : v[15:8];
                word.is_data = 1'b1;
            end
            hdr_pos++;
        end
        else
        begin
            word.is_data = 1'b1;
            word.data = pix_left[0] ? color_hold[7:0] : color_hold[15:8];
            if (pix_left > 0)
                pix_left--;
            if (pix_left == 0)
            begin
                word.last = 1'b1;
                xfer_active = 1'b0;
                hdr_pos = 0;
            end
        end
        pending_bytes.push_back(word);
    endfunction

    task automatic send_word(input logic cmd, input logic [15:0] left, input logic [15:0] top,
                             input logic [15:0] width, input logic [15:0] height,
                             input logic [15:0] color);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {color, height, width, top, left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fill_model_step(cmd, {color, height, width, top, left});
    endtask

    task automatic pull_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_word(CMD_PULL, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PANEL_WIDTH:  cfg_width = value[PANEL_W-1:0];
            REG_PANEL_HEIGHT: cfg_height = value[PANEL_W-1:0];
            REG_COL_OFFSET:   cfg_col_off = value[OFF_W-1:0];
            REG_ROW_OFFSET:   cfg_row_off = value[OFF_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic hold_receiver(input int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    // reset panel 128x160, no offsets
    task automatic test_directed_shapes();
        pull_bytes(1);
        send_word(CMD_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF);
        pull_bytes(HDR_LEN + 3);
        send_word(CMD_START, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000);
        pull_bytes(3);
        // new start drops the running transfer
        send_word(CMD_START, 16'd127, 16'd159, 16'd1, 16'd1, 16'h8001);
        pull_bytes(HDR_LEN + 2);
        send_word(CMD_START, 16'd5, 16'd5, 16'd0, 16'd3, 16'h1234);
        pull_bytes(1);
        send_word(CMD_START, 16'd5, 16'd5, 16'd3, 16'd0, 16'h1234);
        send_word(CMD_START, 16'd128, 16'd0, 16'd4, 16'd4, 16'h5555);
        send_word(CMD_START, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hAAAA);
        send_word(CMD_START, 16'hFFFB, 16'd0, 16'd5, 16'd1, 16'h0F0F);
        pull_bytes(1);
        send_word(CMD_START, 16'hFFFB, 16'hFFFF, 16'd6, 16'd2, 16'hC3A5);
        pull_bytes(4);
        // empty start while active goes idle
        send_word(CMD_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
        pull_bytes(1);
        send_word(CMD_START, 16'd126, 16'd158, 16'd10, 16'd10, 16'h5AA5);
        pull_bytes(HDR_LEN + 8);
        wait_quiet();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_PANEL_WIDTH, 32'd0);
        send_word(CMD_START, 16'd0, 16'd0, 16'd4, 16'd4, 16'h1111);
        pull_bytes(2);
        wait_quiet();
        write_reg(REG_PANEL_WIDTH, 32'h3FF);
        write_reg(REG_PANEL_HEIGHT, 32'h3FF);
        write_reg(REG_COL_OFFSET, 32'hFF);
        write_reg(REG_ROW_OFFSET, 32'hFF);
        send_word(CMD_START, 16'd500, 16'd510, 16'hFFFF, 16'hFFFF, 16'hFEDC);
        pull_bytes(HDR_LEN + 48);
        wait_quiet();
        write_reg(REG_PANEL_WIDTH, 32'd1);
        write_reg(REG_PANEL_HEIGHT, 32'd1);
        write_reg(REG_COL_OFFSET, 32'd0);
        write_reg(REG_ROW_OFFSET, 32'd0);
        send_word(CMD_START, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h00FF);
        pull_bytes(HDR_LEN + 2);
        wait_quiet();
        write_reg(REG_PANEL_WIDTH, 32'd512);
        write_reg(REG_PANEL_HEIGHT, 32'd0);
        send_word(CMD_START, 16'd0, 16'd0, 16'd4, 16'd4, 16'h2222);
        pull_bytes(2);
        wait_quiet();
    endtask

    // receiver stops while the sender keeps pulling, then sender waits for the tail
    task automatic test_receiver_stall();
        int need;
        write_reg(REG_PANEL_WIDTH, 32'd128);
        write_reg(REG_PANEL_HEIGHT, 32'd160);
        write_reg(REG_COL_OFFSET, 32'd2);
        write_reg(REG_ROW_OFFSET, 32'd1);
        src_idle_pct = 0;
        send_word(CMD_START, 16'd10, 16'd20, 16'd12, 16'd8, 16'hBEEF);
        need = HDR_LEN + pix_left;
        fork
            hold_receiver(400);
            pull_bytes(need);
        join
        wait_quiet();
    endtask

    function automatic logic [15:0] pick_coord(input logic [PANEL_W-1:0] panel);
        int v;
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        v = int'($urandom_range(int'(panel) + 8)) - 4;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'd0;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_panel();
        case ($urandom_range(7))
            0: return 32'd512;
            1: return $urandom_range(513, 1023);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int count;
        int seg_end;
        int need;
        int pulls;
        count = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (count < n_items)
        begin
            wait_quiet();
            write_reg(REG_PANEL_WIDTH, pick_panel());
            write_reg(REG_PANEL_HEIGHT, pick_panel());
            write_reg(REG_COL_OFFSET, $urandom_range(255));
            write_reg(REG_ROW_OFFSET, $urandom_range(255));
            seg_end = count + 95;
            while (count < seg_end && count < n_items)
            begin
                if ($urandom_range(9) == 0)
                begin
                    if (xfer_active)
                        count++;
                    pull_bytes(1);
                end
                else
                begin
                    send_word(CMD_START, pick_coord(cfg_width), pick_coord(cfg_height),
                              pick_len(), pick_len(), 16'($urandom));
                    count++;
                    need = xfer_active ? HDR_LEN + int'(pix_left) : 0;
                    if (need > 150 || (need > 0 && $urandom_range(7) == 0))
                        pulls = $urandom_range(1, (need < 60) ? need : 60);
                    else
                        pulls = need;
                    pull_bytes(pulls);
                    count += pulls;
                    if ($urandom_range(4) == 0)
                        pull_bytes(1);
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_shapes();
        test_register_extremes();
        test_receiver_stall();
        test_random_traffic(25, 71, 400);
        test_random_traffic(71, 25, 400);
        test_random_traffic(0, 0, 400);
        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 3000000);
        $display("Mismatches found");
        $finish;
    end

endmodule
